FILE: hdl/rhd_pkg.sv
package rhd_pkg;

   localparam int FRONT_END_COUNT_DEFAULT = 16;
   localparam int OUT_DEPTH = 4;
   localparam int OUT_PTR_W = 2;
   localparam int OUT_CNT_W = 3;

   localparam logic [31:0] MARK_MASK   = 32'hff00ffff;
   localparam logic [31:0] MARK_CHUNK  = 32'hf000caf0;
   localparam logic [31:0] MARK_HEADER = 32'had00cade;
   localparam logic [31:0] MARK_FOOTER = 32'hcafeff80;

   localparam logic [1:0] KIND_HIT        = 2'd0;
   localparam logic [1:0] KIND_END_OK     = 2'd1;
   localparam logic [1:0] KIND_END_BROKEN = 2'd2;

   typedef enum logic [2:0] {
      PH_SEEK   = 3'd0,
      PH_TIME   = 3'd1,
      PH_COUNT  = 3'd2,
      PH_FRESH  = 3'd3,
      PH_HITS   = 3'd4,
      PH_FORCED = 3'd5
   } rhd_phase_type;

   typedef struct packed {
      rhd_phase_type phase;
      logic [39:0]   crossing;
      logic [31:0]   event_count;
   } rhd_entry_type;

   typedef struct packed {
      logic          en;
      logic [3:0]    fe;
      rhd_entry_type entry;
   } rhd_mem_write_type;

   typedef struct packed {
      logic [1:0]  kind;
      logic [3:0]  front_end;
      logic [39:0] crossing;
      logic [31:0] event_count;
      logic [6:0]  channel;
      logic [5:0]  chip;
      logic [2:0]  adc_code;
      logic [6:0]  chip_crossing;
      logic        chip_full;
      logic        roc_full;
      logic [5:0]  amplitude;
      logic [31:0] raw_word;
   } rhd_result_type;

   function automatic logic is_header(input logic [31:0] w);
      return (w & MARK_MASK) == MARK_HEADER;
   endfunction

   function automatic logic is_chunk_marker(input logic [31:0] w);
      return (w & MARK_MASK) == MARK_CHUNK;
   endfunction

   // halves of the time word swapped into crossing bits 31..0
   function automatic logic [31:0] time_part(input logic [31:0] t);
      return {t[15:0], t[31:16]};
   endfunction

endpackage

FILE: hdl/readout_hit_deframer.sv
// an accepted beat is registered into stage 1; its results go through the result queue to rsp_
// throughput: one payload beat per cycle unless stalled; a last-word hit puts two results out
// stage 0 tracks chunk markers, stage 1 reads-modifies-writes the per-front-end stream memory
// synchronous active-high reset clears chunk tracking, the result queue and the entry valid bits;
// an entry not valid reads as seeking header with zero crossing and counter
// a last word clears every valid bit as it leaves stage 1, so the next subevent starts clean
module readout_hit_deframer #(
   parameter int FRONT_END_COUNT = rhd_pkg::FRONT_END_COUNT_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [31:0] req_data_word,
   input  logic        req_last_word,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_kind,
   output logic [3:0]  rsp_front_end,
   output logic [39:0] rsp_crossing,
   output logic [31:0] rsp_event_count,
   output logic [6:0]  rsp_channel,
   output logic [5:0]  rsp_chip,
   output logic [2:0]  rsp_adc_code,
   output logic [6:0]  rsp_chip_crossing,
   output logic        rsp_chip_full,
   output logic        rsp_roc_full,
   output logic [5:0]  rsp_amplitude,
   output logic [31:0] rsp_raw_word
);

   // chunk tracking (stage 0)
   logic [2:0] chunk_left_ff, chunk_left_in;
   logic [3:0] chunk_owner_ff, chunk_owner_in;

   // stage 1 item
   logic        s1_valid_ff, s1_valid_in;
   logic        s1_parse_ff;
   logic [3:0]  s1_fe_ff;
   logic [31:0] s1_word_ff;
   logic        s1_last_ff;
   logic        s1_broken_ff;

   logic accept;
   logic fire;
   logic room;
   logic is_chunk_word;
   logic is_marker;
   logic owner_in_range;

   rhd_pkg::rhd_entry_type     cur_entry;
   rhd_pkg::rhd_entry_type     nxt_entry;
   rhd_pkg::rhd_mem_write_type mem_wr;
   rhd_pkg::rhd_result_type    hit;
   rhd_pkg::rhd_result_type    end_result;
   rhd_pkg::rhd_result_type    first;
   rhd_pkg::rhd_result_type    out_result;
   logic                       hit_valid;
   logic                       hit_fires;
   logic                       push_first;
   logic                       push_second;

   // stage 1 goes ahead only when the queue can take both possible results
   assign fire      = s1_valid_ff && room;
   assign req_stall = s1_valid_ff && !room;
   assign accept    = req_valid && !req_stall;

   assign is_chunk_word  = (chunk_left_ff != 3'd0);
   assign is_marker      = rhd_pkg::is_chunk_marker(req_data_word);
   assign owner_in_range = ({1'b0, chunk_owner_ff} < 5'(FRONT_END_COUNT));

   // marker and chunk bookkeeping, back to idle at the last word
   always_comb begin
      chunk_left_in  = chunk_left_ff;
      chunk_owner_in = chunk_owner_ff;
      if (accept) begin
         if (is_chunk_word) begin
            chunk_left_in = chunk_left_ff - 3'd1;
         end else if (is_marker) begin
            chunk_owner_in = req_data_word[23:20];
            chunk_left_in  = req_data_word[19:17];
         end
         if (req_last_word) begin
            chunk_left_in  = 3'd0;
            chunk_owner_in = 4'd0;
         end
      end
   end

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (accept) begin
         s1_valid_in = 1'b1;
      end else if (fire) begin
         s1_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         chunk_left_ff  <= 3'd0;
         chunk_owner_ff <= 4'd0;
         s1_valid_ff    <= 1'b0;
      end else begin
         chunk_left_ff  <= chunk_left_in;
         chunk_owner_ff <= chunk_owner_in;
         s1_valid_ff    <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_parse_ff  <= is_chunk_word && owner_in_range;
         s1_fe_ff     <= chunk_owner_ff;
         s1_word_ff   <= req_data_word;
         s1_last_ff   <= req_last_word;
         // last word seen while hunting for a marker and not one itself
         s1_broken_ff <= req_last_word && !is_chunk_word && !is_marker;
      end
   end

   // stream state read at accept and registered, ready for stage 1
   assign mem_wr.en    = fire && s1_parse_ff;
   assign mem_wr.fe    = s1_fe_ff;
   assign mem_wr.entry = nxt_entry;

   rhd_state_mem #(
      .FRONT_END_COUNT(FRONT_END_COUNT)
   ) u_state_mem (
      .clock    (clock),
      .reset    (reset),
      .rd_en    (accept),
      .rd_fe    (chunk_owner_ff),
      .wr       (mem_wr),
      .clear    (fire && s1_last_ff),
      .rd_entry (cur_entry)
   );

   rhd_parse u_parse (
      .cur       (cur_entry),
      .word      (s1_word_ff),
      .fe        (s1_fe_ff),
      .nxt       (nxt_entry),
      .hit_valid (hit_valid),
      .hit       (hit)
   );

   // end-of-subevent result: everything zero but the kind
   always_comb begin
      end_result      = '0;
      end_result.kind = s1_broken_ff ? rhd_pkg::KIND_END_BROKEN : rhd_pkg::KIND_END_OK;
   end

   // hit goes first, the end result behind it
   assign hit_fires   = s1_parse_ff && hit_valid;
   assign push_first  = fire && (hit_fires || s1_last_ff);
   assign push_second = fire && hit_fires && s1_last_ff;
   assign first       = hit_fires ? hit : end_result;

   rhd_result_queue u_result_queue (
      .clock       (clock),
      .reset       (reset),
      .push_first  (push_first),
      .push_second (push_second),
      .first       (first),
      .second      (end_result),
      .room        (room),
      .out_valid   (rsp_valid),
      .out_stall   (rsp_stall),
      .out_result  (out_result)
   );

   assign rsp_kind          = out_result.kind;
   assign rsp_front_end     = out_result.front_end;
   assign rsp_crossing      = out_result.crossing;
   assign rsp_event_count   = out_result.event_count;
   assign rsp_channel       = out_result.channel;
   assign rsp_chip          = out_result.chip;
   assign rsp_adc_code      = out_result.adc_code;
   assign rsp_chip_crossing = out_result.chip_crossing;
   assign rsp_chip_full     = out_result.chip_full;
   assign rsp_roc_full      = out_result.roc_full;
   assign rsp_amplitude     = out_result.amplitude;
   assign rsp_raw_word      = out_result.raw_word;

endmodule

FILE: hdl/rhd_state_mem.sv
module rhd_state_mem #(
   parameter int FRONT_END_COUNT = rhd_pkg::FRONT_END_COUNT_DEFAULT
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      rd_en,
   input  logic [3:0]                rd_fe,
   input  rhd_pkg::rhd_mem_write_type wr,
   input  logic                      clear,
   output rhd_pkg::rhd_entry_type    rd_entry
);

   localparam int AW = (FRONT_END_COUNT > 1) ? $clog2(FRONT_END_COUNT) : 1;

   rhd_pkg::rhd_entry_type mem [FRONT_END_COUNT];
   logic [FRONT_END_COUNT-1:0] valid_ff;
   logic [FRONT_END_COUNT-1:0] valid_in;

   rhd_pkg::rhd_entry_type q_ff;
   rhd_pkg::rhd_entry_type fwd_entry_ff;
   logic q_valid_ff, q_valid_in;
   logic fwd_ff, fwd_in;

   logic [AW-1:0] rd_addr;
   logic [AW-1:0] wr_addr;
   logic          same_entry;

   assign rd_addr    = rd_fe[AW-1:0];
   assign wr_addr    = wr.fe[AW-1:0];
   assign same_entry = wr.en && (wr.fe == rd_fe);

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr_addr] <= wr.entry;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         q_ff         <= mem[rd_addr];
         fwd_entry_ff <= wr.entry;
      end
   end

   always_comb begin
      valid_in = valid_ff;
      if (clear) begin
         valid_in = '0;
      end else if (wr.en) begin
         valid_in[wr_addr] = 1'b1;
      end
   end

   // clear wins over a write-through, then a write to the same entry
   always_comb begin
      q_valid_in = q_valid_ff;
      fwd_in     = fwd_ff;
      if (rd_en) begin
         if (clear) begin
            q_valid_in = 1'b0;
            fwd_in     = 1'b0;
         end else if (same_entry) begin
            q_valid_in = 1'b1;
            fwd_in     = 1'b1;
         end else begin
            q_valid_in = valid_ff[rd_addr];
            fwd_in     = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff   <= '0;
         q_valid_ff <= 1'b0;
         fwd_ff     <= 1'b0;
      end else begin
         valid_ff   <= valid_in;
         q_valid_ff <= q_valid_in;
         fwd_ff     <= fwd_in;
      end
   end

   always_comb begin
      if (!q_valid_ff) begin
         rd_entry = '{phase: rhd_pkg::PH_SEEK, crossing: '0, event_count: '0};
      end else if (fwd_ff) begin
         rd_entry = fwd_entry_ff;
      end else begin
         rd_entry = q_ff;
      end
   end

endmodule

FILE: hdl/rhd_parse.sv
module rhd_parse (
   input  rhd_pkg::rhd_entry_type  cur,
   input  logic [31:0]             word,
   input  logic [3:0]              fe,
   output rhd_pkg::rhd_entry_type  nxt,
   output logic                    hit_valid,
   output rhd_pkg::rhd_result_type hit
);

   logic word_is_header;

   assign word_is_header = rhd_pkg::is_header(word);

   always_comb begin
      nxt       = cur;
      hit_valid = 1'b0;
      case (cur.phase)
         rhd_pkg::PH_FORCED: begin
            nxt.crossing = {word[23:16], 32'h0};
            nxt.phase    = rhd_pkg::PH_TIME;
         end
         rhd_pkg::PH_TIME: begin
            nxt.crossing = {cur.crossing[39:32], rhd_pkg::time_part(word)};
            nxt.phase    = rhd_pkg::PH_COUNT;
         end
         rhd_pkg::PH_COUNT: begin
            nxt.event_count = word;
            nxt.phase       = rhd_pkg::PH_FRESH;
         end
         rhd_pkg::PH_FRESH, rhd_pkg::PH_HITS: begin
            if (word_is_header) begin
               // counter word that looked like a header becomes the header
               if (cur.phase == rhd_pkg::PH_FRESH && rhd_pkg::is_header(cur.event_count)) begin
                  nxt.crossing = {cur.event_count[23:16], rhd_pkg::time_part(word)};
                  nxt.phase    = rhd_pkg::PH_COUNT;
               end else begin
                  nxt.crossing = {word[23:16], 32'h0};
                  nxt.phase    = rhd_pkg::PH_TIME;
               end
            end else if (word == rhd_pkg::MARK_FOOTER) begin
               nxt.phase = rhd_pkg::PH_FORCED;
            end else begin
               nxt.phase = rhd_pkg::PH_HITS;
               hit_valid = 1'b1;
            end
         end
         default: begin
            if (word_is_header) begin
               nxt.crossing = {word[23:16], 32'h0};
               nxt.phase    = rhd_pkg::PH_TIME;
            end else begin
               nxt.phase = rhd_pkg::PH_SEEK;
            end
         end
      endcase
   end

   always_comb begin
      hit.kind          = rhd_pkg::KIND_HIT;
      hit.front_end     = fe;
      hit.crossing      = cur.crossing;
      hit.event_count   = cur.event_count;
      hit.channel       = word[22:16];
      hit.chip          = word[28:23];
      hit.adc_code      = word[31:29];
      hit.chip_crossing = word[6:0];
      hit.chip_full     = word[7];
      hit.roc_full      = word[8];
      hit.amplitude     = word[14:9];
      hit.raw_word      = word;
   end

endmodule

FILE: hdl/rhd_result_queue.sv
module rhd_result_queue (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    push_first,
   input  logic                    push_second,
   input  rhd_pkg::rhd_result_type first,
   input  rhd_pkg::rhd_result_type second,
   output logic                    room,
   output logic                    out_valid,
   input  logic                    out_stall,
   output rhd_pkg::rhd_result_type out_result
);

   rhd_pkg::rhd_result_type slot_ff [rhd_pkg::OUT_DEPTH];

   logic [rhd_pkg::OUT_PTR_W-1:0] head_ff, head_in;
   logic [rhd_pkg::OUT_PTR_W-1:0] tail_ff, tail_in;
   logic [rhd_pkg::OUT_CNT_W-1:0] count_ff, count_in;
   logic [rhd_pkg::OUT_PTR_W-1:0] tail_next;
   logic [rhd_pkg::OUT_CNT_W-1:0] n_push;
   logic                          pop;

   assign out_valid  = (count_ff != '0);
   assign out_result = slot_ff[head_ff];
   assign pop        = out_valid && !out_stall;
   // two free places guaranteed for the worst-case item
   assign room       = (count_ff <= rhd_pkg::OUT_CNT_W'(rhd_pkg::OUT_DEPTH - 2));
   assign tail_next  = tail_ff + rhd_pkg::OUT_PTR_W'(1);

   always_comb begin
      n_push   = rhd_pkg::OUT_CNT_W'(push_first) + rhd_pkg::OUT_CNT_W'(push_second);
      tail_in  = tail_ff + n_push[rhd_pkg::OUT_PTR_W-1:0];
      head_in  = pop ? head_ff + rhd_pkg::OUT_PTR_W'(1) : head_ff;
      count_in = count_ff + n_push - rhd_pkg::OUT_CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (push_first) begin
         slot_ff[tail_ff] <= first;
      end
      if (push_second) begin
         slot_ff[tail_next] <= second;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
      end else begin
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
      end
   end

endmodule

FILE: tb/rhd_checker.sv
module rhd_checker #(
   parameter int FRONT_END_COUNT = rhd_pkg::FRONT_END_COUNT_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_stall,
   input  logic [31:0] req_data_word,
   input  logic        req_last_word,
   input  logic        rsp_valid,
   input  logic        rsp_stall,
   input  logic [1:0]  rsp_kind,
   input  logic [3:0]  rsp_front_end,
   input  logic [39:0] rsp_crossing,
   input  logic [31:0] rsp_event_count,
   input  logic [6:0]  rsp_channel,
   input  logic [5:0]  rsp_chip,
   input  logic [2:0]  rsp_adc_code,
   input  logic [6:0]  rsp_chip_crossing,
   input  logic        rsp_chip_full,
   input  logic        rsp_roc_full,
   input  logic [5:0]  rsp_amplitude,
   input  logic [31:0] rsp_raw_word,
   output int          fault_count,
   output int          results_owed
);

   // own copy of the chunk tracker and the per-front-end stream parsers
   logic [2:0]              chunk_left;
   logic [3:0]              chunk_owner;
   rhd_pkg::rhd_phase_type  stream_phase [16];
   logic [39:0]             stream_crossing [16];
   logic [31:0]             stream_count [16];
   rhd_pkg::rhd_result_type results_due [$];

   function automatic logic header_pattern(input logic [31:0] w);
      return (w & rhd_pkg::MARK_MASK) == rhd_pkg::MARK_HEADER;
   endfunction

   function automatic string describe_result(input rhd_pkg::rhd_result_type r);
      return $sformatf({"kind %0d fe %0d crossing %h count %h channel %0d chip %0d",
                        " adc %0d bco %0d chip_full %0d roc_full %0d amp %0d raw %h"},
                       r.kind, r.front_end, r.crossing, r.event_count, r.channel, r.chip,
                       r.adc_code, r.chip_crossing, r.chip_full, r.roc_full, r.amplitude,
                       r.raw_word);
   endfunction

   function automatic string differing_fields(input rhd_pkg::rhd_result_type a,
                                              input rhd_pkg::rhd_result_type e);
      string d;
      d = "";
      if (a.kind !== e.kind)                   d = {d, " kind"};
      if (a.front_end !== e.front_end)         d = {d, " front_end"};
      if (a.crossing !== e.crossing)           d = {d, " crossing"};
      if (a.event_count !== e.event_count)     d = {d, " event_count"};
      if (a.channel !== e.channel)             d = {d, " channel"};
      if (a.chip !== e.chip)                   d = {d, " chip"};
      if (a.adc_code !== e.adc_code)           d = {d, " adc_code"};
      if (a.chip_crossing !== e.chip_crossing) d = {d, " chip_crossing"};
      if (a.chip_full !== e.chip_full)         d = {d, " chip_full"};
      if (a.roc_full !== e.roc_full)           d = {d, " roc_full"};
      if (a.amplitude !== e.amplitude)         d = {d, " amplitude"};
      if (a.raw_word !== e.raw_word)           d = {d, " raw_word"};
      return d;
   endfunction

   task automatic clear_streams;
      chunk_left  = '0;
      chunk_owner = '0;
      for (int i = 0; i < 16; i++) begin
         stream_phase[i]    = rhd_pkg::PH_SEEK;
         stream_crossing[i] = '0;
         stream_count[i]    = '0;
      end
   endtask

   task automatic parse_stream_word(input int fe, input logic [31:0] w);
      rhd_pkg::rhd_result_type hit;
      rhd_pkg::rhd_phase_type  ph;
      ph = stream_phase[fe];
      case (ph)
         rhd_pkg::PH_FORCED: begin
            stream_crossing[fe] = {w[23:16], 32'h0};
            stream_phase[fe]    = rhd_pkg::PH_TIME;
         end
         rhd_pkg::PH_TIME: begin
            stream_crossing[fe] = {stream_crossing[fe][39:32], w[15:0], w[31:16]};
            stream_phase[fe]    = rhd_pkg::PH_COUNT;
         end
         rhd_pkg::PH_COUNT: begin
            stream_count[fe] = w;
            stream_phase[fe] = rhd_pkg::PH_FRESH;
         end
         rhd_pkg::PH_FRESH, rhd_pkg::PH_HITS: begin
            if (header_pattern(w)) begin
               // counter word that looked like a header becomes the header
               if (ph == rhd_pkg::PH_FRESH && header_pattern(stream_count[fe])) begin
                  stream_crossing[fe] = {stream_count[fe][23:16], w[15:0], w[31:16]};
                  stream_phase[fe]    = rhd_pkg::PH_COUNT;
               end else begin
                  stream_crossing[fe] = {w[23:16], 32'h0};
                  stream_phase[fe]    = rhd_pkg::PH_TIME;
               end
            end else if (w == rhd_pkg::MARK_FOOTER) begin
               stream_phase[fe] = rhd_pkg::PH_FORCED;
            end else begin
               stream_phase[fe]  = rhd_pkg::PH_HITS;
               hit               = '0;
               hit.kind          = rhd_pkg::KIND_HIT;
               hit.front_end     = fe[3:0];
               hit.crossing      = stream_crossing[fe];
               hit.event_count   = stream_count[fe];
               hit.channel       = w[22:16];
               hit.chip          = w[28:23];
               hit.adc_code      = w[31:29];
               hit.chip_crossing = w[6:0];
               hit.chip_full     = w[7];
               hit.roc_full      = w[8];
               hit.amplitude     = w[14:9];
               hit.raw_word      = w;
               results_due.insert(results_due.size(), hit);
            end
         end
         default: begin
            if (header_pattern(w)) begin
               stream_crossing[fe] = {w[23:16], 32'h0};
               stream_phase[fe]    = rhd_pkg::PH_TIME;
            end else begin
               stream_phase[fe] = rhd_pkg::PH_SEEK;
            end
         end
      endcase
   endtask

   task automatic deframe_word(input logic [31:0] w, input logic last);
      rhd_pkg::rhd_result_type fin;
      logic                    broken;
      int                      fe;
      broken = 1'b0;
      if (chunk_left != 0) begin
         fe         = int'(chunk_owner);
         chunk_left = chunk_left - 3'd1;
         if (fe < FRONT_END_COUNT) parse_stream_word(fe, w);
      end else if ((w & rhd_pkg::MARK_MASK) == rhd_pkg::MARK_CHUNK) begin
         chunk_owner = w[23:20];
         chunk_left  = w[19:17];
      end else if (last) begin
         broken = 1'b1;
      end
      if (last) begin
         fin      = '0;
         fin.kind = broken ? rhd_pkg::KIND_END_BROKEN : rhd_pkg::KIND_END_OK;
         results_due.insert(results_due.size(), fin);
         clear_streams();
      end
   endtask

   always @(posedge clock) begin : watch
      rhd_pkg::rhd_result_type seen;
      rhd_pkg::rhd_result_type want;
      string                   diff;
      if (reset) begin
         results_due.delete();
         clear_streams();
      end else begin
         if (req_valid && !req_stall) deframe_word(req_data_word, req_last_word);
         if (rsp_valid && !rsp_stall) begin
            seen = {rsp_kind, rsp_front_end, rsp_crossing, rsp_event_count, rsp_channel,
                    rsp_chip, rsp_adc_code, rsp_chip_crossing, rsp_chip_full, rsp_roc_full,
                    rsp_amplitude, rsp_raw_word};
            if (results_due.size() == 0) begin
               fault_count = fault_count + 1;
               if (fault_count <= 10)
                  $display("unexpected result beat: %s", describe_result(seen));
            end else begin
               want = results_due.pop_front();
               diff = differing_fields(seen, want);
               if (diff != "") begin
                  fault_count = fault_count + 1;
                  if (fault_count <= 10) begin
                     $display("result beat mismatch in%s", diff);
                     $display("  expected %s", describe_result(want));
                     $display("  actual   %s", describe_result(seen));
                  end
               end
            end
         end
      end
      results_owed <= results_due.size();
   end

endmodule

FILE: tb/readout_hit_deframer_tb.sv
module readout_hit_deframer_tb;

   localparam int CYCLE_LIMIT  = 300000;
   localparam int RANDOM_BEATS = 800;
   // extra idle cycles once the checker owes no more results, to cover any stragglers
   localparam int DRAIN_CYCLES = 8;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [31:0] req_data_word = '0;
   logic        req_last_word = 1'b0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [1:0]  rsp_kind;
   logic [3:0]  rsp_front_end;
   logic [39:0] rsp_crossing;
   logic [31:0] rsp_event_count;
   logic [6:0]  rsp_channel;
   logic [5:0]  rsp_chip;
   logic [2:0]  rsp_adc_code;
   logic [6:0]  rsp_chip_crossing;
   logic        rsp_chip_full;
   logic        rsp_roc_full;
   logic [5:0]  rsp_amplitude;
   logic [31:0] rsp_raw_word;

   int fault_count;
   int results_owed;
   int beats_sent = 0;

   // idling switches, flipped per subevent so that some stretches run flat out
   bit sender_gaps    = 1'b1;
   bit receiver_stall = 1'b1;

   always #4 clock = ~clock;

   readout_hit_deframer i_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_data_word     (req_data_word),
      .req_last_word     (req_last_word),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_kind          (rsp_kind),
      .rsp_front_end     (rsp_front_end),
      .rsp_crossing      (rsp_crossing),
      .rsp_event_count   (rsp_event_count),
      .rsp_channel       (rsp_channel),
      .rsp_chip          (rsp_chip),
      .rsp_adc_code      (rsp_adc_code),
      .rsp_chip_crossing (rsp_chip_crossing),
      .rsp_chip_full     (rsp_chip_full),
      .rsp_roc_full      (rsp_roc_full),
      .rsp_amplitude     (rsp_amplitude),
      .rsp_raw_word      (rsp_raw_word)
   );

   rhd_checker i_checker (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_data_word     (req_data_word),
      .req_last_word     (req_last_word),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_kind          (rsp_kind),
      .rsp_front_end     (rsp_front_end),
      .rsp_crossing      (rsp_crossing),
      .rsp_event_count   (rsp_event_count),
      .rsp_channel       (rsp_channel),
      .rsp_chip          (rsp_chip),
      .rsp_adc_code      (rsp_adc_code),
      .rsp_chip_crossing (rsp_chip_crossing),
      .rsp_chip_full     (rsp_chip_full),
      .rsp_roc_full      (rsp_roc_full),
      .rsp_amplitude     (rsp_amplitude),
      .rsp_raw_word      (rsp_raw_word),
      .fault_count       (fault_count),
      .results_owed      (results_owed)
   );

   // chunk marker: front end in bits 23..20, length in 19..17, bit 16 is free
   function automatic logic [31:0] chunk_marker(input logic [3:0] fe, input logic [2:0] len);
      return rhd_pkg::MARK_CHUNK | {8'h0, fe, len, 1'($urandom_range(0, 1)), 16'h0};
   endfunction

   // header with random bits 23..16, the top byte of the crossing
   function automatic logic [31:0] random_header;
      return rhd_pkg::MARK_HEADER | ($urandom() & ~rhd_pkg::MARK_MASK);
   endfunction

   // one payload beat: optional idle gap, then hold until accepted
   task automatic send_word(input logic [31:0] w, input logic last);
      int gap;
      gap = sender_gaps ? $urandom_range(0, 10) : 0;
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_data_word <= w;
      req_last_word <= last;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      beats_sent++;
   endtask

   // stop sending and let every predicted result come out
   task automatic wait_drained;
      req_valid <= 1'b0;
      @(posedge clock);
      while (results_owed != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // one random subevent; a clean one is markers and well-formed streams,
   // a noisy one adds stray words between chunks and cuts or spoils the end
   task automatic send_subevent(input bit noisy);
      logic [31:0] beats [$];
      bit          fe_started [16];
      logic [3:0]  fe;
      int          n_chunks, len, k, pick, style, keep;
      foreach (fe_started[i]) fe_started[i] = 1'b0;
      n_chunks = $urandom_range(1, 8);
      for (int c = 0; c < n_chunks; c++) begin
         if (noisy && $urandom_range(0, 3) == 0) beats.insert(beats.size(), $urandom());
         // a few front ends most of the time, so streams carry on across chunks
         fe  = ($urandom_range(0, 9) < 7) ? 4'($urandom_range(0, 3)) : 4'($urandom_range(0, 15));
         len = $urandom_range(0, 7);
         beats.insert(beats.size(), chunk_marker(fe, 3'(len)));
         k = 0;
         while (k < len) begin
            pick = $urandom_range(0, 99);
            if (!fe_started[fe] && pick < 85) begin
               beats.insert(beats.size(), random_header());
               k += 1;
            end else if (pick < 4 && len - k >= 4) begin
               // header, time, counter that looks like a header, then a header
               beats.insert(beats.size(), random_header());
               beats.insert(beats.size(), $urandom());
               beats.insert(beats.size(), random_header());
               beats.insert(beats.size(), random_header());
               k += 4;
            end else if (pick < 14) begin
               beats.insert(beats.size(), random_header());
               k += 1;
            end else if (pick < 19) begin
               beats.insert(beats.size(), rhd_pkg::MARK_FOOTER);
               k += 1;
            end else if (pick < 21) begin
               // marker pattern inside a chunk is plain data
               beats.insert(beats.size(),
                            chunk_marker(4'($urandom_range(0, 15)), 3'($urandom_range(0, 7))));
               k += 1;
            end else begin
               beats.insert(beats.size(), $urandom());
               k += 1;
            end
            fe_started[fe] = 1'b1;
         end
      end
      style = noisy ? $urandom_range(0, 2) : 0;
      if (style == 1) begin
         keep = $urandom_range(1, beats.size());
         while (beats.size() > keep) void'(beats.pop_back());
      end else if (style == 2) begin
         beats.insert(beats.size(), $urandom());
      end
      foreach (beats[i]) send_word(beats[i], i == beats.size() - 1);
   endtask

   // receiver: random stall before each result beat, then take it
   initial begin : receiver
      int stall_len;
      forever begin
         stall_len = receiver_stall ? $urandom_range(0, 10) : 0;
         if (stall_len != 0) begin
            rsp_stall <= 1'b1;
            repeat (stall_len) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         @(posedge clock);
         while (rsp_valid !== 1'b1) @(posedge clock);
      end
   end

   // hard stop if the block hangs
   initial begin : watchdog
      repeat (CYCLE_LIMIT) @(posedge clock);
      $display("RESULT: ERROR");
      $finish;
   end

   initial begin : stimulus
      bit paused;
      paused = 1'b0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: full chunk to front end 0 with extreme header, time, count and hits,
      // then a footer whose next word is forced into a header
      send_word(chunk_marker(4'd0, 3'd7), 1'b0);
      send_word(32'hadffcade, 1'b0);
      send_word(32'hffffffff, 1'b0);
      send_word(32'h00000000, 1'b0);
      send_word(32'hffffffff, 1'b0);
      send_word(32'h00000000, 1'b0);
      send_word(rhd_pkg::MARK_FOOTER, 1'b0);
      send_word(32'h5a3c1234, 1'b0);
      // front end 15: counter word that looks like a header, followed by a header
      send_word(chunk_marker(4'd15, 3'd7), 1'b0);
      send_word(32'had00cade, 1'b0);
      send_word(32'h0000ffff, 1'b0);
      send_word(32'had42cade, 1'b0);
      send_word(32'had11cade, 1'b0);
      send_word(32'hffffffff, 1'b0);
      send_word(32'h12345678, 1'b0);
      send_word(32'h87654321, 1'b1);
      // empty chunk, stray word between chunks, header triple cut by the end
      send_word(chunk_marker(4'd3, 3'd0), 1'b0);
      send_word(32'h00000001, 1'b0);
      send_word(chunk_marker(4'd3, 3'd5), 1'b0);
      send_word(32'had07cade, 1'b0);
      send_word(32'h89abcdef, 1'b1);
      // hit-like word while seeking a header, then a broken end
      send_word(chunk_marker(4'd1, 3'd1), 1'b0);
      send_word(32'h00000000, 1'b0);
      send_word(32'hdeadbeef, 1'b1);
      // marker as the last word
      send_word(chunk_marker(4'd9, 3'd6), 1'b1);
      wait_drained();

      beats_sent = 0;
      while (beats_sent < RANDOM_BEATS) begin
         sender_gaps    = $urandom_range(0, 3) != 0;
         receiver_stall = $urandom_range(0, 3) != 0;
         send_subevent($urandom_range(0, 4) == 0);
         // hold off once midway until the block has emptied
         if (!paused && beats_sent >= RANDOM_BEATS / 2) begin
            wait_drained();
            paused = 1'b1;
         end
      end
      wait_drained();

      if (fault_count == 0 && results_owed == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule

FILE: readout_hit_deframer.f
hdl/rhd_pkg.sv
hdl/rhd_state_mem.sv
hdl/rhd_parse.sv
hdl/rhd_result_queue.sv
hdl/readout_hit_deframer.sv
tb/rhd_checker.sv
tb/readout_hit_deframer_tb.sv
